// File: src/bounded_stack_with_search_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the stack RTL.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication
`define BSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bss_pkg.sv
// ---------------------------------------------------------------------------
// Stack package
// Operation and status codes, cell control bundle and fixed field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_FIND  = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic find;
    logic rd;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/bounded_stack_with_search.sv
// ---------------------------------------------------------------------------
// Bounded stack with search
// Shift-register LIFO of cells with push, pop, find, read at depth and clear.
// ---------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tuser: func; tdata: value, position
//  m_axis    out        tuser: status; tdata: top, occupancy, flags, matches
//
//  An operation runs from accept to the next accept through the cell load,
//  each level of the registered match tree and the capture of the result
//  register; no new transaction is accepted before the result is captured.
//  Reset clears the occupancy and the control state; no clearing pass.
//  A stalled result holds its register; the next transaction enters in the
//  cycle the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bounded_stack_with_search_macros.svh"

module bounded_stack_with_search #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // func
  input  wire [bss_pkg::FUNC_W-1:0]    s_tuser,
  // value, position, zero padding
  input  wire [((DATA_WIDTH+bss_pkg::POS_W+7)/8)*8-1:0] s_tdata,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // status
  output logic [bss_pkg::STATUS_W-1:0] m_tuser,
  // top_value, occupancy, is_empty, found, found_position, read_value, padding
  output logic [((2*DATA_WIDTH+2*$clog2(STACK_DEPTH+1)+2+7)/8)*8-1:0] m_tdata
);
  import bss_pkg::*;

  localparam int CNTW  = $clog2(STACK_DEPTH+1);
  localparam int IDXW  = $clog2(STACK_DEPTH);
  localparam int CMPW  = (CNTW > POS_W) ? CNTW : POS_W;
  localparam int OUT_W = ((2*DATA_WIDTH+2*CNTW+2+7)/8)*8;
  localparam int WAITW = $clog2(IDXW+1);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t           state;
  logic [WAITW-1:0] wait_cnt;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  count_next;
  status_t          status;
  status_t          status_next;

  logic                  accept;
  op_t                   op;
  logic [DATA_WIDTH-1:0] key;
  logic [POS_W-1:0]      position;
  cell_ctrl_t            ctrl;

  logic [STACK_DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
  logic [STACK_DEPTH-1:0][DATA_WIDTH-1:0] cell_rdata;
  logic [STACK_DEPTH-1:0]                 cell_hit;

  logic                  root_hit;
  logic [IDXW-1:0]       root_idx;
  logic [DATA_WIDTH-1:0] root_data;
  logic [DATA_WIDTH-1:0] top_word;
  logic [CNTW-1:0]       found_pos;
  logic                  full;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign key      = s_tdata[DATA_WIDTH-1:0];
  assign position = s_tdata[DATA_WIDTH +: POS_W];
  assign full     = count == CNTW'(STACK_DEPTH);

  always_comb begin
    ctrl        = '0;
    ctrl.load   = accept;
    count_next  = count;
    status_next = ST_OK;
    case (op)
      OP_PUSH: begin
        if (full) begin
          status_next = ST_OVER;
        end else begin
          ctrl.push  = 1'b1;
          count_next = count + CNTW'(1);
        end
      end
      OP_POP: begin
        if (count == '0) begin
          status_next = ST_UNDER;
        end else begin
          ctrl.pop   = 1'b1;
          count_next = count - CNTW'(1);
        end
      end
      OP_FIND: begin
        ctrl.find = 1'b1;
      end
      OP_READ: begin
        ctrl.rd = 1'b1;
        if (!(CMPW'(position) < CMPW'(count))) begin
          status_next = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_data;
    logic [DATA_WIDTH-1:0] down_data;
    if (i == 0) begin : g_top
      assign up_data = key;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
    end
    if (i == STACK_DEPTH-1) begin : g_bottom
      assign down_data = cell_data[i];
    end else begin : g_upper
      assign down_data = cell_data[i+1];
    end
    bss_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .STACK_DEPTH(STACK_DEPTH),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key      (key),
      .position (position),
      .count    (count),
      .up_data  (up_data),
      .down_data(down_data),
      .data     (cell_data[i]),
      .hit      (cell_hit[i]),
      .rdata    (cell_rdata[i])
    );
  end

  bss_tree #(
    .DATA_WIDTH (DATA_WIDTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_tree (
    .clk      (clk),
    .leaf_hit (cell_hit),
    .leaf_data(cell_rdata),
    .root_hit (root_hit),
    .root_idx (root_idx),
    .root_data(root_data)
  );

  assign top_word  = (count == '0) ? '0 : cell_data[0];
  assign found_pos = root_hit ? (CNTW'(root_idx) + CNTW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wait_cnt <= '0;
      count    <= '0;
      status   <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count    <= count_next;
            status   <= status_next;
            wait_cnt <= '0;
            state    <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (wait_cnt == WAITW'(IDXW)) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            m_tdata  <= OUT_W'({root_data, found_pos, root_hit, count == '0, count,
                                top_word});
            state    <= S_IDLE;
          end else begin
            wait_cnt <= wait_cnt + WAITW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, (state == S_BUSY) && !m_tvalid, "accept did not start the tree wait")
  `BSS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNTW'(STACK_DEPTH), "occupancy beyond depth")
  `BSS_ASSERT_NOW(a_out_count, clk, rst, m_tvalid, m_tdata[DATA_WIDTH +: CNTW] == count, "result occupancy differs from stack")

endmodule

`default_nettype wire

// File: src/bss_cell.sv
// ---------------------------------------------------------------------------
// Stack cell
// One stack entry at a fixed depth; shifts with its neighbours and produces
// its match flag and read word for the reduction tree.
// ---------------------------------------------------------------------------
`default_nettype none

module bss_cell #(
  parameter int DATA_WIDTH  = 32,
  parameter int STACK_DEPTH = 16,
  parameter int INDEX       = 0
) (
  input  wire                                   clk,
  input  bss_pkg::cell_ctrl_t                   ctrl,
  input  wire [DATA_WIDTH-1:0]                  key,
  input  wire [bss_pkg::POS_W-1:0]              position,
  input  wire [$clog2(STACK_DEPTH+1)-1:0]       count,
  input  wire [DATA_WIDTH-1:0]                  up_data,
  input  wire [DATA_WIDTH-1:0]                  down_data,
  output logic [DATA_WIDTH-1:0]                 data,
  output logic                                  hit,
  output logic [DATA_WIDTH-1:0]                 rdata
);
  import bss_pkg::*;

  localparam int CNTW = $clog2(STACK_DEPTH+1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

  logic occupied;
  logic selected;

  assign occupied = CNTW'(INDEX) < count;
  assign selected = CMPW'(position) == CMPW'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.push) begin
        data <= up_data;
      end else if (ctrl.pop) begin
        data <= down_data;
      end
      hit   <= ctrl.find && occupied && (data == key);
      rdata <= (ctrl.rd && occupied && selected) ? data : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/bss_tree.sv
// ---------------------------------------------------------------------------
// Match reduction tree
// Registered binary tree picking the deepest matching cell and merging the
// selected read word, one level per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bss_tree #(
  parameter int DATA_WIDTH  = 32,
  parameter int STACK_DEPTH = 16
) (
  input  wire                                   clk,
  input  wire [STACK_DEPTH-1:0]                 leaf_hit,
  input  wire [STACK_DEPTH-1:0][DATA_WIDTH-1:0] leaf_data,
  output logic                                  root_hit,
  output logic [$clog2(STACK_DEPTH)-1:0]        root_idx,
  output logic [DATA_WIDTH-1:0]                 root_data
);
  import bss_pkg::*;

  localparam int IDXW   = $clog2(STACK_DEPTH);
  localparam int LEAVES = 1 << IDXW;

  logic                  l_hit  [LEAVES];
  logic [IDXW-1:0]       l_idx  [LEAVES];
  logic [DATA_WIDTH-1:0] l_data [LEAVES];

  logic                  n_hit  [1:LEAVES-1];
  logic [IDXW-1:0]       n_idx  [1:LEAVES-1];
  logic [DATA_WIDTH-1:0] n_data [1:LEAVES-1];

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      l_idx[i] = IDXW'(i);
      if (i < STACK_DEPTH) begin
        l_hit[i]  = leaf_hit[i];
        l_data[i] = leaf_data[i];
      end else begin
        l_hit[i]  = 1'b0;
        l_data[i] = '0;
      end
    end
  end

  // prefer the deeper (right) child on a match
  always_ff @(posedge clk) begin
    for (int n = 1; n < LEAVES; n++) begin
      if (2 * n >= LEAVES) begin
        n_hit[n]  <= l_hit[2*n-LEAVES] || l_hit[2*n+1-LEAVES];
        n_idx[n]  <= l_hit[2*n+1-LEAVES] ? l_idx[2*n+1-LEAVES] : l_idx[2*n-LEAVES];
        n_data[n] <= l_data[2*n-LEAVES] | l_data[2*n+1-LEAVES];
      end else begin
        n_hit[n]  <= n_hit[2*n] || n_hit[2*n+1];
        n_idx[n]  <= n_hit[2*n+1] ? n_idx[2*n+1] : n_idx[2*n];
        n_data[n] <= n_data[2*n] | n_data[2*n+1];
      end
    end
  end

  assign root_hit  = n_hit[1];
  assign root_idx  = n_idx[1];
  assign root_data = n_data[1];

endmodule

`default_nettype wire

// File: dv/bounded_stack_with_search_tb.sv
// ---------------------------------------------------------------------------
// Bounded stack with search testbench
// Drives push, pop, find, read-at and clear transactions into the stack,
// predicts every result from a model of the stack held here, and compares
// each result field by field under random source idling and sink stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_search_tb;
  import bss_pkg::*;

  localparam int SD        = 16;
  localparam int DW        = 32;
  localparam int CW        = $clog2(SD + 1);
  localparam int S_TDATA_W = ((DW + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * DW + 2 * CW + 2 + 7) / 8) * 8;
  localparam int RAND_OPS  = 700;
  localparam int DRAIN_CYC = 20;

  typedef struct packed {
    status_t       status;
    logic [DW-1:0] top;
    logic [CW-1:0] occ;
    logic          empty;
    logic          found;
    logic [CW-1:0] fpos;
    logic [DW-1:0] rd;
  } lifo_result_t;

  class lifo_tracker;
    logic [DW-1:0] cells[SD];
    int            level;
    lifo_result_t  expected_results[$];
    int            errors;
    int            op_seen[5];
    int            status_seen[4];
    int            find_hits;
    int            results_seen;

    function int pending();
      return expected_results.size();
    endfunction

    function int occupancy();
      return level;
    endfunction

    function logic [DW-1:0] peek(int depth);
      return cells[level - 1 - depth];
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    function void note_op(op_t op, logic [DW-1:0] v, logic [POS_W-1:0] p);
      lifo_result_t r;
      int           where;
      int           d;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (level >= SD) begin
            r.status = ST_OVER;
          end else begin
            cells[level] = v;
            level++;
          end
        end
        OP_POP: begin
          if (level == 0) r.status = ST_UNDER;
          else level--;
        end
        OP_FIND: begin
          where = 0;
          for (d = 0; d < level; d++)
            if (cells[level - 1 - d] == v) where = d + 1;
          if (where != 0) begin
            r.found = 1'b1;
            r.fpos  = CW'(where);
            find_hits++;
          end
        end
        OP_READ: begin
          if (p < level) r.rd = cells[level - 1 - p];
          else r.status = ST_RANGE;
        end
        OP_CLEAR: level = 0;
        default: ;
      endcase
      r.top   = (level != 0) ? cells[level - 1] : '0;
      r.occ   = CW'(level);
      r.empty = (level == 0);
      op_seen[op]++;
      status_seen[r.status]++;
      expected_results.push_back(r);
    endfunction

    task check_result(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] d);
      lifo_result_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected transaction", 64'(0), d[63:0]);
      end else begin
        e = expected_results.pop_front();
        if (st !== e.status) report("status", 64'(e.status), 64'(st));
        if (d[DW-1:0] !== e.top) report("top_value", 64'(e.top), 64'(d[DW-1:0]));
        if (d[DW +: CW] !== e.occ) report("occupancy", 64'(e.occ), 64'(d[DW +: CW]));
        if (d[DW+CW] !== e.empty) report("is_empty", 64'(e.empty), 64'(d[DW+CW]));
        if (d[DW+CW+1] !== e.found) report("found", 64'(e.found), 64'(d[DW+CW+1]));
        if (d[DW+CW+2 +: CW] !== e.fpos)
          report("found_position", 64'(e.fpos), 64'(d[DW+CW+2 +: CW]));
        if (d[DW+2*CW+2 +: DW] !== e.rd)
          report("read_value", 64'(e.rd), 64'(d[DW+2*CW+2 +: DW]));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [FUNC_W-1:0]    s_tuser;   // func
  logic [S_TDATA_W-1:0] s_tdata;   // value, position, zero padding
  logic                 m_tvalid;
  logic                 m_tready;
  logic [STATUS_W-1:0]  m_tuser;   // status
  // top_value, occupancy, is_empty, found, found_position, read_value, padding
  logic [M_TDATA_W-1:0] m_tdata;

  int src_idle_pct;
  int snk_stall_pct;

  lifo_tracker sb;

  logic [DW-1:0] value_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                                   32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000,
                                   32'h1234_5678, 32'hDEAD_BEEF};

  bounded_stack_with_search #(
    .STACK_DEPTH(SD),
    .DATA_WIDTH (DW)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  initial begin
    #5_000_000;
    $display("bounded_stack_with_search: mismatch");
    $finish;
  end

  // Entered and left just after a falling edge.
  task automatic drive_op(op_t op, logic [DW-1:0] v, logic [POS_W-1:0] p);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W - DW - POS_W){1'b0}}, p, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_op(op, v, p);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_ops(int n);
    bit            grow;
    int            i;
    int            k;
    int            lvl;
    op_t           op;
    logic [DW-1:0] v;
    logic [3:0]    p;
    grow = 1'b1;
    for (i = 0; i < n; i++) begin
      if (i % 90 == 89) wait_drained();
      lvl = sb.occupancy();
      if (lvl == SD && $urandom_range(3) == 0) grow = 1'b0;
      if (lvl == 0 && $urandom_range(3) == 0) grow = 1'b1;
      k = $urandom_range(99);
      if (k < 3) op = OP_CLEAR;
      else if (k < 20) op = OP_READ;
      else if (k < 36) op = OP_FIND;
      else if (k < 46) op = grow ? OP_POP : OP_PUSH;
      else op = grow ? OP_PUSH : OP_POP;
      v = ($urandom_range(2) == 0) ? $urandom : value_pool[$urandom_range(7)];
      if (op == OP_FIND && lvl != 0 && $urandom_range(1) == 0)
        v = sb.peek($urandom_range(lvl - 1));
      if (lvl != 0 && $urandom_range(9) < 7) p = 4'($urandom_range(lvl - 1));
      else p = 4'($urandom_range(15));
      drive_op(op, v, p);
    end
  endtask

  initial begin
    int i;
    sb            = new();
    src_idle_pct  = 6;
    snk_stall_pct = 48;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= '0;
    s_tdata  <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty-stack corner cases
    drive_op(OP_POP,  32'h0, 4'd0);
    drive_op(OP_FIND, 32'h0, 4'd0);
    drive_op(OP_READ, 32'h0, 4'd0);
    drive_op(OP_READ, 32'hFFFF_FFFF, 4'd15);
    // duplicates to check the deepest match wins
    drive_op(OP_PUSH, 32'hFFFF_FFFF, 4'd0);
    drive_op(OP_PUSH, 32'h0000_0000, 4'd15);
    drive_op(OP_PUSH, 32'hA5A5_A5A5, 4'd0);
    drive_op(OP_PUSH, 32'hFFFF_FFFF, 4'd0);
    drive_op(OP_FIND, 32'hFFFF_FFFF, 4'd0);
    drive_op(OP_FIND, 32'h1234_5678, 4'd0);
    drive_op(OP_READ, 32'h0, 4'd0);
    drive_op(OP_READ, 32'h0, 4'd3);
    drive_op(OP_READ, 32'h0, 4'd4);
    // fill, then overflow
    for (i = 0; i < SD - 4; i++) drive_op(OP_PUSH, 32'h100 + i, 4'($urandom));
    drive_op(OP_PUSH, 32'hDEAD_BEEF, 4'd0);
    drive_op(OP_READ, 32'h0, 4'd15);
    drive_op(OP_FIND, 32'hFFFF_FFFF, 4'd15);
    drive_op(OP_POP,  32'h0, 4'd0);
    drive_op(OP_CLEAR, 32'h0, 4'd0);
    drive_op(OP_POP,  32'h0, 4'd0);
    wait_drained();

    random_ops(RAND_OPS / 3);
    wait_drained();
    src_idle_pct  = 48;
    snk_stall_pct = 6;
    random_ops(RAND_OPS / 3);
    wait_drained();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    random_ops(RAND_OPS - 2 * (RAND_OPS / 3));

    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);

    $display("ops: push %0d pop %0d find %0d read %0d clear %0d, results %0d",
             sb.op_seen[OP_PUSH], sb.op_seen[OP_POP], sb.op_seen[OP_FIND],
             sb.op_seen[OP_READ], sb.op_seen[OP_CLEAR], sb.results_seen);
    $display("overflow %0d underflow %0d out of range %0d find hits %0d errors %0d",
             sb.status_seen[ST_OVER], sb.status_seen[ST_UNDER],
             sb.status_seen[ST_RANGE], sb.find_hits, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bounded_stack_with_search: match");
    end else begin
      $display("bounded_stack_with_search: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+src
src/bss_pkg.sv
src/bss_cell.sv
src/bss_tree.sv
src/bounded_stack_with_search.sv
dv/bounded_stack_with_search_tb.sv
